// ===== sv/npcs_pkg.sv =====
// shared types and constants for the nearest palette color search block
// no dependencies; imported by npcs_dist, npcs_ram users and the top level
`default_nettype none

package npcs_pkg;

  localparam int COUNT_W    = 6;
  localparam int DIST_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;
  localparam logic [DIST_W-1:0]  DIST_START  = 12'hFFF;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic MODE_WEIGHTED = 1'b0;
  localparam logic MODE_PLAIN    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MODE = 2'd1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // stored palette word: alpha 31..24, blue 23..16, green 15..8, red 7..0
  typedef struct packed {
    logic [7:0] alpha;
    rgb_t       color;
  } pal_word_t;

  typedef struct packed {
    logic       command;
    logic [4:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        best_index;
    logic [7:0]        best_red;
    logic [7:0]        best_green;
    logic [7:0]        best_blue;
    logic [7:0]        best_alpha;
    logic [DIST_W-1:0] best_distance;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ===== sv/npcs_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module npcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/npcs_dist.sv =====
// manhattan color distance, weighted 3/4/2 or plain
// depends on npcs_pkg
`default_nettype none

module npcs_dist (
  input  wire npcs_pkg::rgb_t              pixel,
  input  wire npcs_pkg::rgb_t              entry,
  input  wire logic                        mode,
  output logic [npcs_pkg::DIST_W-1:0]      distance
);

  import npcs_pkg::*;

  logic [7:0] dr, dg, db;

  always_comb begin
    dr = (pixel.red   > entry.red)   ? pixel.red   - entry.red   : entry.red   - pixel.red;
    dg = (pixel.green > entry.green) ? pixel.green - entry.green : entry.green - pixel.green;
    db = (pixel.blue  > entry.blue)  ? pixel.blue  - entry.blue  : entry.blue  - pixel.blue;
    if (mode == MODE_PLAIN) begin
      distance = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
    end else begin
      // 3*dr + 4*dg + 2*db, at most 2295
      distance = (DIST_W'(dr) << 1) + DIST_W'(dr) + (DIST_W'(dg) << 2) + (DIST_W'(db) << 1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/nearest_palette_color_search.sv =====
// top level of the nearest palette color search block
// depends on npcs_pkg, npcs_ram and npcs_dist
`default_nettype none

// Palette lookup engine. An item with command write stores one RGBA entry in
// the palette ram and gives no result; busy stays low. A lookup item raises
// busy and scans entries 0 .. n-1, n being palette_count clipped to
// PALETTE_ENTRIES (at least entry 0 is read when the count is zero), one ram
// read per cycle. The single read port of the palette ram sets the pace: a
// lookup runs from acceptance through the scan and a drain state to the
// registered out_valid strobe. The result shows for exactly one cycle on
// out_data with out_valid high; there is no backpressure, so capture it then.
// A new item may be started in the same cycle as that strobe. Ties go to the
// lowest index. With a count of zero the result is entry 0 with distance
// 4095. Writes to an entry index at or beyond PALETTE_ENTRIES are dropped.
// Configuration writes are always taken and should only be issued while busy
// is low; index 0 is palette_count, index 1 distance_mode, others ignored.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // item input
  input  wire logic                              start,
  output logic                                   busy,
  input  wire npcs_pkg::in_item_t                in_data,
  // result output
  output logic                                   out_valid,
  output npcs_pkg::out_item_t                    out_data,
  // configuration write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [npcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [npcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import npcs_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  // wide enough for the count register and for PALETTE_ENTRIES itself
  localparam int CW = ($clog2(PALETTE_ENTRIES + 1) > COUNT_W) ?
                      $clog2(PALETTE_ENTRIES + 1) : COUNT_W;

  // configuration registers
  logic [COUNT_W-1:0] palette_count_r;
  logic               distance_mode_r;

  // scan control
  state_t             state_r, state_nxt;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]      scan_last_r;
  logic               count_zero_r;
  rgb_t               pix_r;
  logic               rd_en;

  // compare stage, working in the cycle after the ram address
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;
  pal_word_t          rd_word;
  logic [DIST_W-1:0]  entry_dist;

  logic [AW-1:0]      best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]  best_dist_r, best_dist_nxt;
  pal_word_t          best_word_r, best_word_nxt;

  // result register
  logic               out_valid_r;
  out_item_t          out_item_r;

  // accept decode
  logic               accept;
  logic               wr_en;
  logic [CW-1:0]      cnt_ext;
  logic [CW-1:0]      cnt_eff;
  pal_word_t          wr_word;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // palette write, dropped when the index lies beyond the ram
  assign wr_en = accept && (in_data.command == CMD_WRITE) &&
                 (CW'(in_data.entry_index) < CW'(PALETTE_ENTRIES));

  always_comb begin
    wr_word.alpha       = in_data.alpha;
    wr_word.color.blue  = in_data.blue;
    wr_word.color.green = in_data.green;
    wr_word.color.red   = in_data.red;
  end

  // effective count, clipped to the ram depth
  always_comb begin
    cnt_ext = CW'(palette_count_r);
    cnt_eff = (cnt_ext > CW'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES) : cnt_ext;
  end

  npcs_ram #(
    .WIDTH ($bits(pal_word_t)),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_word)
  );

  npcs_dist u_dist (
    .pixel    (pix_r),
    .entry    (rd_word.color),
    .mode     (distance_mode_r),
    .distance (entry_dist)
  );

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_count_r <= COUNT_RESET;
      distance_mode_r <= MODE_WEIGHTED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PALETTE_COUNT: palette_count_r <= cfg_data[COUNT_W-1:0];
        REG_DISTANCE_MODE: distance_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // scan sequencer: one ram read per cycle, then a drain state for the last compare
  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    rd_en       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        rd_addr_nxt = '0;
        if (accept && (in_data.command == CMD_LOOKUP)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_addr_r == scan_last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_addr_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_addr_r <= rd_addr_nxt;
      rd_vld_r  <= rd_en;
    end
  end

  // lookup operands latched on acceptance
  always_ff @(posedge clk) begin
    if (accept && (in_data.command == CMD_LOOKUP)) begin
      pix_r.red    <= in_data.red;
      pix_r.green  <= in_data.green;
      pix_r.blue   <= in_data.blue;
      count_zero_r <= (cnt_eff == '0);
      scan_last_r  <= (cnt_eff == '0) ? '0 : AW'(cnt_eff - 1'b1);
    end
    rd_idx_r <= rd_addr_r;
  end

  // running minimum; entry 0 always seeds it, strict compare keeps lowest index
  always_comb begin
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    best_word_nxt = best_word_r;
    if (rd_vld_r && ((rd_idx_r == '0) || (entry_dist < best_dist_r))) begin
      best_idx_nxt  = rd_idx_r;
      best_word_nxt = rd_word;
      // empty search keeps the start distance but still reports entry 0
      best_dist_nxt = ((rd_idx_r == '0) && count_zero_r) ? DIST_START : entry_dist;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    best_word_r <= best_word_nxt;
  end

  // result register, loaded as the last compare lands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN) begin
      out_item_r.best_index    <= 5'(best_idx_nxt);
      out_item_r.best_red      <= best_word_nxt.color.red;
      out_item_r.best_green    <= best_word_nxt.color.green;
      out_item_r.best_blue     <= best_word_nxt.color.blue;
      out_item_r.best_alpha    <= best_word_nxt.alpha;
      out_item_r.best_distance <= best_dist_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a result only ever follows the drain cycle of a scan
  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DRAIN))
    else $error("result strobe without a finished scan");

  // the read address never runs past the last entry of the scan
  a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_addr_r <= scan_last_r))
    else $error("scan address beyond the searched range");

  // an accepted lookup starts a scan in the next cycle
  a_lookup_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command == CMD_LOOKUP)) |=> (state_r == ST_SCAN))
    else $error("accepted lookup did not start a scan");

  // ram reads happen only while scanning, and never alongside a palette write
  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("palette read and write in the same cycle");
`endif

endmodule

`default_nettype wire
